@@ src/bucket_bitmap_slot_allocator_assert.svh @@
// Assertion macros used by the checker file of the slot allocator.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef BUCKET_BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define BUCKET_BITMAP_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BBSA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define BBSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ src/bbsa_pkg.sv @@
// Shared constants, types and helper functions of the slot allocator.
// Depends on nothing; every other .sv source file imports it.
`default_nettype none

package bbsa_pkg;

   localparam int NUM_BUCKETS      = 16;
   localparam int SLOTS_PER_BUCKET = 64;
   localparam int BUCKET_W         = 4;
   localparam int SLOT_W           = 6;
   localparam int MAP_W            = 64;
   localparam int CNT_W            = 5;

   localparam logic [MAP_W-1:0] FULL_MASK = {MAP_W{1'b1}} >> (MAP_W - SLOTS_PER_BUCKET);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK            = 2'd0;
   localparam logic [1:0] ST_NO_BUCKET     = 2'd1;
   localparam logic [1:0] ST_NOT_ALLOCATED = 2'd2;

   typedef struct packed {
      logic                pop;
      logic                push;
      logic [BUCKET_W-1:0] push_bucket;
   } stk_cmd_type;

   typedef struct packed {
      logic                empty;
      logic [BUCKET_W-1:0] top;
   } stk_stat_type;

   function automatic logic [SLOT_W-1:0] lowest_zero(input logic [MAP_W-1:0] map);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--) begin
         if (!map[i]) begin
            idx = SLOT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

@@ src/bucket_bitmap_slot_allocator.sv @@
// Top level of the bucket bitmap slot allocator: request decode and bitmap update.
// Depends on bbsa_pkg, bbsa_map_ram and bbsa_stack.
//
//   Channel   Handshake              Ports
//   request   start high, busy low   req_opcode, req_free_bucket, req_free_slot
//   response  rsp_valid, one cycle   rsp_status, rsp_given_bucket, rsp_given_slot
//
// Each request has two steps: the bitmap memory read, then the update and write back.
// The response appears in the cycle in which busy falls; a new request may be taken then.
// Busy is high for the one cycle of the bitmap update, and no request is taken while it is high.
// Reset is synchronous and leaves all bitmaps empty with bucket 0 on the stack.
// The receiver cannot stall responses; none is ever held back.
`default_nettype none

module bucket_bitmap_slot_allocator
   import bbsa_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output      logic                busy,
   input  wire logic                req_opcode,
   input  wire logic [BUCKET_W-1:0] req_free_bucket,
   input  wire logic [SLOT_W-1:0]   req_free_slot,
   output      logic                rsp_valid,
   output      logic [1:0]          rsp_status,
   output      logic [BUCKET_W-1:0] rsp_given_bucket,
   output      logic [SLOT_W-1:0]   rsp_given_slot
);

   logic                busy_ff;
   logic                op_ff;
   logic [BUCKET_W-1:0] bkt_ff, bkt_in;
   logic [SLOT_W-1:0]   slot_ff;
   logic                bad_ff, bad_in;
   logic [CNT_W-1:0]    inuse_ff;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [BUCKET_W-1:0] rsp_bucket_ff, rsp_bucket_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;

   logic                accept;
   logic                take_fresh;
   logic [MAP_W-1:0]    map;
   logic [MAP_W-1:0]    slot_bit;
   logic [MAP_W-1:0]    wr_map;
   logic                map_full;
   logic                wr_en;
   logic [SLOT_W-1:0]   low_slot;
   stk_cmd_type         stk_cmd;
   stk_stat_type        stk_stat;

   assign accept = start && !busy_ff;

   always_comb begin
      take_fresh = 1'b0;
      bad_in     = 1'b0;
      bkt_in     = req_free_bucket;
      if (req_opcode == OP_ALLOC) begin
         if (!stk_stat.empty) begin
            bkt_in = stk_stat.top;
         end else if (inuse_ff < CNT_W'(NUM_BUCKETS)) begin
            bkt_in     = inuse_ff[BUCKET_W-1:0];
            take_fresh = 1'b1;
         end else begin
            bad_in = 1'b1;
         end
      end else begin
         bad_in = ({1'b0, req_free_bucket} >= inuse_ff) ||
                  ({1'b0, req_free_slot} >= (SLOT_W + 1)'(SLOTS_PER_BUCKET));
      end
   end

   bbsa_map_ram u_map_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (bkt_in),
      .rd_data (map),
      .wr_en   (wr_en),
      .wr_addr (bkt_ff),
      .wr_data (wr_map)
   );

   always_comb begin
      map_full      = ((map & FULL_MASK) == FULL_MASK);
      low_slot      = lowest_zero(map);
      slot_bit      = '0;
      wr_map        = map;
      wr_en         = 1'b0;
      rsp_status_in = ST_OK;
      rsp_bucket_in = '0;
      rsp_slot_in   = '0;
      stk_cmd       = '0;
      stk_cmd.pop   = accept && (req_opcode == OP_ALLOC) && !stk_stat.empty;
      stk_cmd.push_bucket = bkt_ff;
      if (busy_ff) begin
         if (op_ff == OP_ALLOC) begin
            slot_bit[low_slot] = 1'b1;
            if (bad_ff || map_full) begin
               rsp_status_in = ST_NO_BUCKET;
            end else begin
               wr_map        = map | slot_bit;
               wr_en         = 1'b1;
               stk_cmd.push  = ((wr_map & FULL_MASK) != FULL_MASK);
               rsp_bucket_in = bkt_ff;
               rsp_slot_in   = low_slot;
            end
         end else begin
            slot_bit[slot_ff] = 1'b1;
            if (bad_ff || ((map & slot_bit) == '0)) begin
               rsp_status_in = ST_NOT_ALLOCATED;
            end else begin
               wr_map       = map & ~slot_bit;
               wr_en        = 1'b1;
               stk_cmd.push = map_full;
            end
         end
      end
   end

   bbsa_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stk_cmd),
      .stat  (stk_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         inuse_ff     <= CNT_W'(1);
      end else begin
         rsp_valid_ff <= busy_ff;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            busy_ff <= 1'b0;
         end
         if (accept && take_fresh) begin
            inuse_ff <= inuse_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_opcode;
         bkt_ff  <= bkt_in;
         slot_ff <= req_free_slot;
         bad_ff  <= bad_in;
      end
      if (busy_ff) begin
         rsp_status_ff <= rsp_status_in;
         rsp_bucket_ff <= rsp_bucket_in;
         rsp_slot_ff   <= rsp_slot_in;
      end
   end

   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_given_bucket = rsp_bucket_ff;
   assign rsp_given_slot   = rsp_slot_ff;

endmodule

`default_nettype wire

@@ src/bbsa_map_ram.sv @@
// Occupancy bitmap memory: one synchronous read port, one write port.
// Per-entry valid bits make never-written bitmaps read as zero after reset.
// Depends on bbsa_pkg.
`default_nettype none

module bbsa_map_ram
   import bbsa_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rd_en,
   input  wire logic [BUCKET_W-1:0] rd_addr,
   output      logic [MAP_W-1:0]    rd_data,
   input  wire logic                wr_en,
   input  wire logic [BUCKET_W-1:0] wr_addr,
   input  wire logic [MAP_W-1:0]    wr_data
);

   logic [MAP_W-1:0]       map_mem [NUM_BUCKETS];
   logic [NUM_BUCKETS-1:0] vld_ff;
   logic [MAP_W-1:0]       rd_data_ff;
   logic                   rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

@@ src/bbsa_stack.sv @@
// Stack of buckets that are in use and not full, with its depth counter.
// Depends on bbsa_pkg.
`default_nettype none

module bbsa_stack
   import bbsa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire stk_cmd_type  cmd,
   output      stk_stat_type stat
);

   logic [BUCKET_W-1:0] stk_ff [NUM_BUCKETS];
   logic [CNT_W-1:0]    depth_ff;
   logic [CNT_W-1:0]    top_idx;

   assign top_idx    = depth_ff - CNT_W'(1);
   assign stat.empty = (depth_ff == '0);
   assign stat.top   = stk_ff[top_idx[BUCKET_W-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            stk_ff[i] <= '0;
         end
         depth_ff <= CNT_W'(1);
      end else if (cmd.pop) begin
         if (depth_ff != '0) begin
            depth_ff <= top_idx;
         end
      end else if (cmd.push) begin
         if (depth_ff < CNT_W'(NUM_BUCKETS)) begin
            stk_ff[depth_ff[BUCKET_W-1:0]] <= cmd.push_bucket;
            depth_ff                       <= depth_ff + CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

@@ src/bbsa_checker.sv @@
// Port-level checker for the slot allocator, bound to the top level.
// Depends on bbsa_pkg and bucket_bitmap_slot_allocator_assert.svh.
`default_nettype none

`include "bucket_bitmap_slot_allocator_assert.svh"

module bbsa_checker
   import bbsa_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire logic                rsp_valid,
   input wire logic [1:0]          rsp_status,
   input wire logic [BUCKET_W-1:0] rsp_given_bucket,
   input wire logic [SLOT_W-1:0]   rsp_given_slot
);

   logic rsp_err;

   assign rsp_err = rsp_valid && (rsp_status != ST_OK);

   `BBSA_ASSERT_NEXT(a_take_sets_busy, clock, reset, start && !busy, busy)
   `BBSA_ASSERT_NEXT(a_busy_gives_rsp, clock, reset, busy, !busy && rsp_valid)
   `BBSA_ASSERT_NOW(a_rsp_needs_busy, clock, reset, rsp_valid, $past(busy))
   `BBSA_ASSERT_NOW(a_err_rsp_zero, clock, reset, rsp_err, !(|{rsp_given_bucket, rsp_given_slot}))
   `BBSA_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_status <= ST_NOT_ALLOCATED)

endmodule

bind bucket_bitmap_slot_allocator bbsa_checker u_bbsa_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_given_bucket (rsp_given_bucket),
   .rsp_given_slot   (rsp_given_slot)
);

`default_nettype wire
